// ===== design/pdts_pkg.sv =====
// Package for the piezo drum trigger scanner: payload structs, register
// indexes, pad modes and the queue entry type. No dependencies.
package pdts_pkg;

  localparam int PADS        = 8;
  localparam int SAMPLE_BITS = 10;
  localparam int PAD_W       = 3;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_CAPTURE = 2'd1;
  localparam logic [1:0] MODE_MUTED   = 2'd2;

  localparam logic [2:0] HIHAT_PAD = 3'd4;
  localparam logic [2:0] CHOKE_PAD = 3'd0;
  localparam logic [6:0] VEL_MIN   = 7'd30;
  localparam logic [6:0] VEL_MAX   = 7'd127;
  localparam logic [6:0] VEL_SPAN  = 7'd97;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_MAX_HIT   = 3'd1;
  localparam logic [2:0] REG_CAPTURE   = 3'd2;
  localparam logic [2:0] REG_MUTE      = 3'd3;
  localparam logic [2:0] REG_XT_WIN    = 3'd4;
  localparam logic [2:0] REG_XT_FACTOR = 3'd5;
  localparam logic [2:0] REG_HH_NOTE   = 3'd6;
  localparam logic [2:0] REG_NOTE_MAP  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 56;

  typedef struct packed {
    logic [2:0]  pad;
    logic [9:0]  sample;
    logic [31:0] time_us;
    logic [31:0] time_ms;
    logic        hihat_closed;
    logic        choke_pressed;
  } in_item_t;

  typedef struct packed {
    logic [2:0] hit_pad;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       is_choke;
  } out_item_t;

  // A job handed from the front to the back: either a finished choke event
  // or a hit whose velocity still has to be computed.
  typedef struct packed {
    logic [2:0] pad;
    logic [6:0] note;
    logic [9:0] peak;
    logic       is_choke;
  } job_t;

endpackage

// ===== design/pdts_front.sv =====
// Front part: per-pad state machines, crosstalk check, job generation.
// Depends on pdts_pkg.
module pdts_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pdts_pkg::in_item_t   in_data,
  input  logic [9:0]           threshold,
  input  logic [15:0]          capture_us,
  input  logic [19:0]          mute_us,
  input  logic [15:0]          xt_win_ms,
  input  logic [15:0]          xt_factor,
  input  logic [6:0]           hh_note,
  input  logic [55:0]          note_map,
  output logic                 job_valid,
  input  logic                 job_full,
  output pdts_pkg::job_t       job
);

  logic [1:0]  mode_r  [pdts_pkg::PADS];
  logic [9:0]  peak_r  [pdts_pkg::PADS];
  logic [31:0] timer_r [pdts_pkg::PADS];
  logic [31:0] last_ms_r;
  logic [9:0]  last_peak_r;

  logic        acc;
  logic [2:0]  p;
  logic [1:0]  m0, m1, mode_nxt;
  logic [31:0] t0, timer_nxt;
  logic [9:0]  pk, peak_nxt;
  logic        choke, emit_hit, xt;
  logic [6:0]  pnote;
  logic [25:0] noise_prod;

  assign in_stall = job_full;
  assign acc      = in_valid && !job_full;
  assign p        = in_data.pad;
  assign pnote    = note_map[7*p +: 7];
  // The noise level always follows the peak of the last emitted hit and the current factor.
  assign noise_prod = last_peak_r * xt_factor;

  always_comb begin
    m0 = mode_r[p];
    t0 = timer_r[p];
    pk = peak_r[p];
    choke = (p == pdts_pkg::CHOKE_PAD) && in_data.choke_pressed
            && (m0 != pdts_pkg::MODE_MUTED);
    m1 = choke ? pdts_pkg::MODE_MUTED : m0;
    if (choke) t0 = in_data.time_us;
    mode_nxt  = m1;
    timer_nxt = t0;
    peak_nxt  = pk;
    emit_hit  = 1'b0;
    xt        = 1'b0;
    unique case (m1)
      pdts_pkg::MODE_IDLE: begin
        if (in_data.sample > threshold) begin
          mode_nxt  = pdts_pkg::MODE_CAPTURE;
          timer_nxt = in_data.time_us;
          peak_nxt  = in_data.sample;
        end
      end
      pdts_pkg::MODE_CAPTURE: begin
        if (in_data.sample > pk) peak_nxt = in_data.sample;
        if ((in_data.time_us - t0) >= {16'd0, capture_us}) begin
          xt = ((in_data.time_ms - last_ms_r) <= {16'd0, xt_win_ms})
               && (peak_nxt <= noise_prod[25:16]);
          emit_hit  = !xt;
          mode_nxt  = pdts_pkg::MODE_MUTED;
          timer_nxt = in_data.time_us;
        end
      end
      default: begin
        if ((in_data.time_us - t0) >= {12'd0, mute_us})
          mode_nxt = pdts_pkg::MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pdts_pkg::PADS; i++) begin
        mode_r[i]  <= pdts_pkg::MODE_IDLE;
        peak_r[i]  <= '0;
        timer_r[i] <= '0;
      end
      last_ms_r   <= '0;
      last_peak_r <= '0;
    end else begin
      if (acc) begin
        mode_r[p]  <= mode_nxt;
        peak_r[p]  <= peak_nxt;
        timer_r[p] <= timer_nxt;
        if (emit_hit) begin
          last_ms_r   <= in_data.time_ms;
          last_peak_r <= peak_nxt;
        end
      end
    end
  end

  // Hit and choke cannot both happen: a choke leaves the pad muted.
  assign job_valid    = acc && (choke || emit_hit);
  assign job.pad      = p;
  assign job.is_choke = choke;
  assign job.peak     = peak_nxt;
  assign job.note     = (!choke && p == pdts_pkg::HIHAT_PAD && in_data.hihat_closed)
                        ? hh_note : pnote;

  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc && choke && emit_hit)) else $error("choke and hit together");
  a_hit_mutes: assert property (@(posedge clk) disable iff (!rst_n)
    acc && emit_hit |=> mode_r[$past(p)] == pdts_pkg::MODE_MUTED)
    else $error("pad not muted after hit");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    job_full |-> !job_valid) else $error("job pushed into full queue");

endmodule

// ===== design/pdts_queue.sv =====
// Two-entry job queue between front and back. Depends on pdts_pkg.
module pdts_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pdts_pkg::job_t  push_data,
  output logic            full,
  output logic            not_empty,
  input  logic            pop,
  output pdts_pkg::job_t  pop_data
);

  pdts_pkg::job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign pop_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count overflow");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from empty queue");
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");

endmodule

// ===== design/pdts_back.sv =====
// Back part: velocity mapping with a restoring divider, output register.
// Depends on pdts_pkg.
module pdts_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [9:0]           threshold,
  input  logic [9:0]           max_hit,
  input  logic                 job_avail,
  input  pdts_pkg::job_t       job,
  output logic                 job_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pdts_pkg::out_item_t  out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [16:0] num_r;      // |numerator| up to 1023*97
  logic [9:0]  den_r;      // |denominator|
  logic [16:0] quo_r;
  logic [10:0] rem_r;
  logic [4:0]  cnt_r;
  logic        neg_r;
  logic [2:0]  pad_r;
  logic [6:0]  note_r;
  logic        choke_r;
  logic        ovalid_r;
  pdts_pkg::out_item_t odata_r;

  logic signed [10:0] dn, nd;
  logic [10:0] adn, and_;
  logic [16:0] nmag;
  logic [11:0] rsh;
  logic [11:0] rsub;
  logic        out_free;
  logic [6:0]  vel;

  assign out_free = !ovalid_r || !out_stall;
  assign dn  = $signed({1'b0, max_hit}) - $signed({1'b0, threshold});
  assign nd  = $signed({1'b0, job.peak}) - $signed({1'b0, threshold});
  assign adn = dn[10] ? 11'(-dn) : 11'(dn);
  assign and_ = nd[10] ? 11'(-nd) : 11'(nd);
  assign nmag = 17'(and_ * pdts_pkg::VEL_SPAN);
  assign rsh  = {rem_r, num_r[16]};
  assign rsub = rsh - {2'd0, den_r};

  // Quotient sign: negative when numerator and divisor differ in sign.
  always_comb begin
    vel = pdts_pkg::VEL_MAX;
    if (neg_r) begin
      // truncated quotient <= 0, so v <= 30: clamp to minimum
      vel = pdts_pkg::VEL_MIN;
    end else if (quo_r >= 17'd97) begin
      vel = pdts_pkg::VEL_MAX;
    end else begin
      vel = 7'(quo_r) + pdts_pkg::VEL_MIN;
    end
  end

  assign job_pop = (st_r == ST_IDLE) && job_avail;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (job_avail) st_nxt = (job.is_choke || dn == 0) ? ST_OUT : ST_DIV;
      ST_DIV:  if (cnt_r == 5'd16) st_nxt = ST_OUT;
      ST_OUT:  if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      st_r <= st_nxt;
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      if (st_r == ST_OUT && out_free) ovalid_r <= 1'b1;
      if (st_r == ST_DIV) cnt_r <= cnt_r + 5'd1;
      else cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: if (job_avail) begin
        pad_r   <= job.pad;
        note_r  <= job.note;
        choke_r <= job.is_choke;
        num_r   <= nmag;
        den_r   <= adn[9:0];
        rem_r   <= '0;
        quo_r   <= '0;
        // zero numerator gives quotient 0, i.e. velocity 30, either sign
        neg_r  <= (nd[10] != dn[10]) && (nd != 0);
        if (job.is_choke) begin
          quo_r <= '0;
          neg_r <= 1'b0;
        end else if (dn == 0) begin
          quo_r <= 17'd97;
          neg_r <= 1'b0;
        end
      end
      ST_DIV: begin
        num_r <= {num_r[15:0], 1'b0};
        if (!rsub[11]) begin
          rem_r <= rsub[10:0];
          quo_r <= {quo_r[15:0], 1'b1};
        end else begin
          rem_r <= rsh[10:0];
          quo_r <= {quo_r[15:0], 1'b0};
        end
      end
      ST_OUT: if (out_free) begin
        odata_r.hit_pad  <= pad_r;
        odata_r.note     <= note_r;
        odata_r.is_choke <= choke_r;
        odata_r.velocity <= choke_r ? 7'd0 : vel;
      end
      default: ;
    endcase
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && out_stall |=> ovalid_r) else $error("result dropped");
  a_vel: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !odata_r.is_choke |-> odata_r.velocity >= pdts_pkg::VEL_MIN)
    else $error("hit velocity below minimum");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> st_r == ST_IDLE) else $error("pop while busy");

endmodule

// ===== design/piezo_drum_trigger_scanner.sv =====
// Top level of the piezo drum trigger scanner: configuration registers and
// the front, queue and back parts. Depends on pdts_pkg and its submodules.
//
// Usage. The in_ channel carries one ADC sample for one pad together with
// microsecond and millisecond time stamps. A request is taken at a rising
// edge with in_valid high and in_stall low. The front part updates that
// pad's state (idle, capturing, muted) in the same cycle and, for a choke
// or a finished capture that passes the crosstalk check, pushes a job into
// a two-entry queue. The back part pops a job, works out the velocity with
// a restoring divider of one quotient bit per cycle and presents the event
// in an output register on the out_ channel.
// Throughput: the front takes one request per cycle while the queue has
// room. A hit passes the back part's pop, divider steps and output register
// load, which sets the sustained event rate; a choke or a hit with zero
// divisor (max_hit equal to threshold) skips the divider. The back part pops
// a new job only when idle; requests that give no event push no job. When
// the receiver holds out_stall the result stays put, the queue fills and
// in_stall then rises. After a hit, the crosstalk noise level from the new
// peak is used from the next request on. Configuration is written through
// cfg_wr_en, cfg_index and cfg_data; the user must do so only while idle,
// which the block does not enforce. Synchronous reset (rst_n low) loads
// the register defaults and returns all pads to idle.
module piezo_drum_trigger_scanner (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pdts_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pdts_pkg::out_item_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_index,
  input  logic [55:0]          cfg_data
);

  logic [9:0]  thr_r, maxh_r;
  logic [15:0] cap_r, xwin_r, xfac_r;
  logic [19:0] mute_r;
  logic [6:0]  hh_r;
  logic [55:0] nmap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= 10'd150;
      maxh_r <= 10'd409;
      cap_r  <= 16'd1000;
      mute_r <= 20'd50000;
      xwin_r <= 16'd40;
      xfac_r <= 16'd16852;
      hh_r   <= 7'd42;
      nmap_r <= 56'd20447836355909681;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pdts_pkg::REG_THRESHOLD: thr_r  <= cfg_data[9:0];
        pdts_pkg::REG_MAX_HIT:   maxh_r <= cfg_data[9:0];
        pdts_pkg::REG_CAPTURE:   cap_r  <= cfg_data[15:0];
        pdts_pkg::REG_MUTE:      mute_r <= cfg_data[19:0];
        pdts_pkg::REG_XT_WIN:    xwin_r <= cfg_data[15:0];
        pdts_pkg::REG_XT_FACTOR: xfac_r <= cfg_data[15:0];
        pdts_pkg::REG_HH_NOTE:   hh_r   <= cfg_data[6:0];
        pdts_pkg::REG_NOTE_MAP:  nmap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic           job_valid, q_full, q_nempty, q_pop;
  pdts_pkg::job_t job_in, job_out;

  pdts_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .threshold(thr_r), .capture_us(cap_r), .mute_us(mute_r),
    .xt_win_ms(xwin_r), .xt_factor(xfac_r), .hh_note(hh_r), .note_map(nmap_r),
    .job_valid, .job_full(q_full), .job(job_in)
  );

  pdts_queue u_queue (
    .clk, .rst_n, .push(job_valid), .push_data(job_in), .full(q_full),
    .not_empty(q_nempty), .pop(q_pop), .pop_data(job_out)
  );

  pdts_back u_back (
    .clk, .rst_n, .threshold(thr_r), .max_hit(maxh_r),
    .job_avail(q_nempty), .job(job_out), .job_pop(q_pop),
    .out_valid, .out_stall, .out_data
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled event changed");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en && cfg_index == pdts_pkg::REG_THRESHOLD |=> thr_r == $past(cfg_data[9:0]))
    else $error("threshold write lost");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_choke |-> out_data.velocity == 7'd0)
    else $error("choke with nonzero velocity");

endmodule
